// ----- src/i2cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types and constants of the I2C bit-bang master: command codes,
// sequence delays in microseconds, queue item layout and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbb_pkg;

   localparam int DATA_BITS     = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int DLY_US_W      = 5;
   localparam int TPU_W         = 8;
   localparam int DELAY_W       = 13;   // 20 us * 255 ticks fits
   localparam int PHASE_W       = 5;
   localparam int SUB_W         = 2;

   // sequence delays in us
   localparam logic [DLY_US_W-1:0] US_BUS_FREE = 5'd20;
   localparam logic [DLY_US_W-1:0] US_SETUP    = 5'd3;
   localparam logic [DLY_US_W-1:0] US_BIT      = 5'd4;
   localparam logic [DLY_US_W-1:0] US_HOLD     = 5'd5;
   localparam logic [DLY_US_W-1:0] US_RECOVER  = 5'd10;
   localparam logic [DLY_US_W-1:0] US_ACK_LOW  = 5'd2;
   localparam logic [DLY_US_W-1:0] US_NONE     = 5'd0;

   localparam logic [PHASE_W-1:0] SEND_LAST_PHASE = PHASE_W'(3 * DATA_BITS);
   localparam logic [PHASE_W-1:0] RECV_LAST_PHASE = PHASE_W'(2 * DATA_BITS);
   localparam logic [SUB_W-1:0]   SUB_DATA        = 2'd0;
   localparam logic [SUB_W-1:0]   SUB_CLK_HIGH    = 2'd1;
   localparam logic [SUB_W-1:0]   SUB_CLK_LOW     = 2'd2;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_TICKS_WORD = '0;
   localparam logic [TPU_W-1:0]      TPU_RESET      = 8'd1;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_ACK   = 3'd3,
      OP_NOACK = 3'd4,
      OP_CHECK = 3'd5,
      OP_SEND  = 3'd6,
      OP_RECV  = 3'd7
   } i2cbb_op_type;

   typedef struct packed {
      i2cbb_op_type         op;
      logic                 is_cmd;
      logic [DATA_BITS-1:0] tx_byte;
      logic                 sda_in;
   } i2cbb_item_type;

endpackage

`default_nettype wire

// ----- src/i2cbb_front.sv -----
// ----------------------------------------------------------------------------
// i2cbb_front
// Accepts request items, tags commands apart from ticks and holds them in a
// short queue for the bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbb_front #(
   parameter int DEPTH = i2cbb_pkg::QUEUE_DEPTH
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [2:0]                        req_operation,
   input  wire  [i2cbb_pkg::DATA_BITS-1:0]   req_tx_byte,
   input  wire                               req_sda_in,
   output logic                              head_valid,
   output i2cbb_pkg::i2cbb_item_type         head_item,
   input  wire                               head_pop
);
   import i2cbb_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   i2cbb_item_type       entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   i2cbb_item_type       new_item;
   logic                 push;
   logic                 full;

   always_comb begin
      new_item.op      = i2cbb_op_type'(req_operation);
      new_item.is_cmd  = (i2cbb_op_type'(req_operation) != OP_TICK);
      new_item.tx_byte = req_tx_byte;
      new_item.sda_in  = req_sda_in;
   end

   assign full       = (count_ff == FULL_CNT);
   assign req_stall  = full;
   assign push       = req_valid && !full;
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

// ----- src/i2cbb_engine.sv -----
// ----------------------------------------------------------------------------
// i2cbb_engine
// Bit engine: walks the pin sequence of the active command, one queue item per
// cycle unless a result stalls, and holds the pin and status result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbb_engine (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [i2cbb_pkg::TPU_W-1:0]       ticks_per_us,
   input  wire                               head_valid,
   input  wire  i2cbb_pkg::i2cbb_item_type   head_item,
   output logic                              head_pop,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_scl_level,
   output logic                              rsp_sda_level,
   output logic                              rsp_sda_drive,
   output logic                              rsp_busy_res,
   output logic                              rsp_done_res,
   output logic [i2cbb_pkg::DATA_BITS-1:0]   rsp_rx_byte,
   output logic                              rsp_ack_ok
);
   import i2cbb_pkg::*;

   i2cbb_op_type          active_ff, active_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [DELAY_W-1:0]    delay_ff, delay_in;
   logic [DATA_BITS-1:0]  shift_ff, shift_in;
   logic [SUB_W-1:0]      sub_ff, sub_in;
   logic [DATA_BITS-1:0]  recv_ff, recv_in;
   logic                  ack_ff, ack_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic                  oe_ff, oe_in;
   logic                  done_ff, done_in;
   logic                  out_valid_ff, out_valid_in;

   logic                  fire;
   logic                  idle;
   logic                  run;
   i2cbb_op_type          cmd_eff;
   logic [PHASE_W-1:0]    phase_eff;
   logic [SUB_W-1:0]      sub_eff;
   logic [DATA_BITS-1:0]  shift_eff;
   logic [DELAY_W-1:0]    delay_dec;
   logic [TPU_W-1:0]      tpu_eff;

   // results of one sequence step
   logic                  s_scl, s_sda, s_oe, s_ack;
   logic [DATA_BITS-1:0]  s_shift, s_recv;
   logic [SUB_W-1:0]      s_sub;
   logic [DLY_US_W-1:0]   s_dly;
   logic                  s_end;
   logic [DATA_BITS-1:0]  shift_sampled;

   assign idle      = (active_ff == OP_TICK);
   assign fire      = head_valid && (!out_valid_ff || !rsp_stall);
   assign head_pop  = fire;
   assign tpu_eff   = (ticks_per_us == '0) ? TPU_W'(1) : ticks_per_us;
   assign delay_dec = (delay_ff != '0) ? delay_ff - 1'b1 : delay_ff;

   always_comb begin
      cmd_eff   = active_ff;
      phase_eff = phase_ff;
      sub_eff   = sub_ff;
      shift_eff = shift_ff;
      run       = (delay_dec == '0);
      if (idle) begin
         cmd_eff   = head_item.op;
         phase_eff = '0;
         sub_eff   = '0;
         if (head_item.op == OP_SEND) begin
            shift_eff = head_item.tx_byte;
         end
         run = head_item.is_cmd;
      end
   end

   assign shift_sampled = {shift_eff[DATA_BITS-2:0], head_item.sda_in};

   always_comb begin
      s_scl   = scl_ff;
      s_sda   = sda_ff;
      s_oe    = oe_ff;
      s_ack   = ack_ff;
      s_shift = shift_eff;
      s_recv  = recv_ff;
      s_sub   = sub_eff;
      s_dly   = US_NONE;
      s_end   = 1'b0;
      unique case (cmd_eff)
         OP_START: begin
            unique case (phase_eff)
               5'd0: begin s_oe = 1'b1; s_dly = US_BUS_FREE; end
               5'd1: begin s_sda = 1'b1; s_dly = US_SETUP; end
               5'd2: begin s_scl = 1'b1; s_dly = US_BIT; end
               5'd3: begin s_sda = 1'b0; s_dly = US_HOLD; end
               5'd4: begin s_scl = 1'b0; s_dly = US_RECOVER; end
               default: s_end = 1'b1;
            endcase
         end
         OP_STOP: begin
            unique case (phase_eff)
               5'd0: begin s_oe = 1'b1; s_sda = 1'b0; s_dly = US_BIT; end
               5'd1: begin s_scl = 1'b1; s_dly = US_BIT; end
               5'd2: begin s_sda = 1'b0; s_dly = US_BIT; end
               5'd3: s_sda = 1'b1;
               default: s_end = 1'b1;
            endcase
         end
         OP_ACK, OP_NOACK: begin
            unique case (phase_eff)
               5'd0: begin
                  s_oe  = 1'b1;
                  s_sda = (cmd_eff == OP_NOACK);
                  s_dly = US_BIT;
               end
               5'd1: begin s_scl = 1'b0; s_dly = US_BIT; end
               5'd2: begin s_scl = 1'b1; s_dly = US_BIT; end
               5'd3: begin
                  s_scl = 1'b0;
                  if (cmd_eff == OP_ACK) begin
                     s_sda = 1'b1;
                  end
               end
               default: s_end = 1'b1;
            endcase
         end
         OP_CHECK: begin
            unique case (phase_eff)
               5'd0: begin s_oe = 1'b0; s_scl = 1'b1; s_dly = US_BIT; end
               5'd1: begin
                  s_ack = !head_item.sda_in;
                  s_scl = 1'b0;
                  s_dly = US_ACK_LOW;
               end
               5'd2: s_oe = 1'b1;
               default: s_end = 1'b1;
            endcase
         end
         OP_SEND: begin
            if (phase_eff < SEND_LAST_PHASE) begin
               s_dly = US_BIT;
               unique case (sub_eff)
                  SUB_DATA: begin
                     s_oe  = 1'b1;
                     s_sda = shift_eff[DATA_BITS-1];
                     s_sub = SUB_CLK_HIGH;
                  end
                  SUB_CLK_HIGH: begin
                     s_scl = 1'b1;
                     s_sub = SUB_CLK_LOW;
                  end
                  SUB_CLK_LOW: begin
                     s_scl   = 1'b0;
                     s_shift = {shift_eff[DATA_BITS-2:0], 1'b0};
                     s_sub   = SUB_DATA;
                  end
                  default: s_sub = SUB_DATA;
               endcase
            end else if (phase_eff == SEND_LAST_PHASE) begin
               s_dly = US_RECOVER;
            end else begin
               s_end = 1'b1;
            end
         end
         OP_RECV: begin
            if (phase_eff == '0) begin
               s_oe    = 1'b0;
               s_scl   = 1'b0;
               s_shift = '0;
               s_dly   = US_BIT;
            end else if (phase_eff <= RECV_LAST_PHASE) begin
               if (phase_eff[0]) begin
                  // odd phases raise scl, even phases sample on the way down
                  s_scl = 1'b1;
                  s_dly = US_BIT;
               end else begin
                  s_shift = shift_sampled;
                  s_scl   = 1'b0;
                  if (phase_eff != RECV_LAST_PHASE) begin
                     s_dly = US_BIT;
                  end else begin
                     s_oe   = 1'b1;
                     s_recv = shift_sampled;
                  end
               end
            end else begin
               s_end = 1'b1;
            end
         end
         default: s_end = 1'b1;
      endcase
   end

   always_comb begin
      active_in    = active_ff;
      phase_in     = phase_ff;
      delay_in     = delay_ff;
      shift_in     = shift_ff;
      sub_in       = sub_ff;
      recv_in      = recv_ff;
      ack_in       = ack_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      oe_in        = oe_ff;
      done_in      = done_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (fire) begin
         out_valid_in = 1'b1;
         done_in      = 1'b0;
         if (!idle) begin
            delay_in = delay_dec;
         end
         if (run) begin
            scl_in   = s_scl;
            sda_in   = s_sda;
            oe_in    = s_oe;
            ack_in   = s_ack;
            shift_in = s_shift;
            recv_in  = s_recv;
            sub_in   = s_sub;
            // a zero delay step is always the last one with pin changes
            if (s_end || s_dly == US_NONE) begin
               active_in = OP_TICK;
               phase_in  = '0;
               delay_in  = '0;
               done_in   = 1'b1;
            end else begin
               active_in = cmd_eff;
               phase_in  = phase_eff + 1'b1;
               delay_in  = DELAY_W'(s_dly) * DELAY_W'(tpu_eff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= OP_TICK;
         phase_ff     <= '0;
         delay_ff     <= '0;
         shift_ff     <= '0;
         sub_ff       <= '0;
         recv_ff      <= '0;
         ack_ff       <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         oe_ff        <= 1'b1;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         phase_ff     <= phase_in;
         delay_ff     <= delay_in;
         shift_ff     <= shift_in;
         sub_ff       <= sub_in;
         recv_ff      <= recv_in;
         ack_ff       <= ack_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         oe_ff        <= oe_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // the state registers only move with a result, so they are the result
   assign rsp_valid     = out_valid_ff;
   assign rsp_scl_level = scl_ff;
   assign rsp_sda_level = sda_ff;
   assign rsp_sda_drive = oe_ff;
   assign rsp_busy_res  = (active_ff != OP_TICK);
   assign rsp_done_res  = done_ff;
   assign rsp_rx_byte   = recv_ff;
   assign rsp_ack_ok    = ack_ff;

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      active_ff == OP_TICK |-> phase_ff == '0 && delay_ff == '0)
      else $error("idle engine with leftover phase or delay");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> active_ff == OP_TICK)
      else $error("done reported while still busy");

   a_cmd_taken: assert property (@(posedge clock) disable iff (reset)
      fire && idle && head_item.is_cmd |=> active_ff != OP_TICK || done_ff)
      else $error("command item neither started nor finished");

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      sub_ff == SUB_DATA || sub_ff == SUB_CLK_HIGH || sub_ff == SUB_CLK_LOW)
      else $error("send substep out of range");

   a_no_move_stalled: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> $stable(phase_ff) && $stable(delay_ff))
      else $error("engine advanced while result stalled");

endmodule

`default_nettype wire

// ----- src/i2c_bitbang_master.sv -----
// ----------------------------------------------------------------------------
// i2c_bitbang_master
// I2C master bit engine: commands and tick items drive the SCL/SDA pin
// sequence; one result item per request item.
// ----------------------------------------------------------------------------
// a request item is registered in the queue, then in the engine result registers
// throughput: one item per cycle while no result is stalled
// a 2-entry queue takes up to two more items while a result is stalled
// reset: engine idle, scl and sda released high with sda driven, ticks_per_us 1
`default_nettype none

module i2c_bitbang_master #(
   parameter int QUEUE_DEPTH = i2cbb_pkg::QUEUE_DEPTH
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [2:0]                          req_operation,
   input  wire  [i2cbb_pkg::DATA_BITS-1:0]     req_tx_byte,
   input  wire                                 req_sda_in,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic                                rsp_scl_level,
   output logic                                rsp_sda_level,
   output logic                                rsp_sda_drive,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [i2cbb_pkg::DATA_BITS-1:0]     rsp_rx_byte,
   output logic                                rsp_ack_ok,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [i2cbb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire  [i2cbb_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [i2cbb_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);
   import i2cbb_pkg::*;

   logic [TPU_W-1:0]   tpu_ff, tpu_in;
   logic               csr_write;
   logic               csr_hit;
   logic               head_valid;
   logic               head_pop;
   i2cbb_item_type     head_item;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == CSR_TICKS_WORD);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = csr_hit ? CSR_DATA_W'(tpu_ff) : '0;

   always_comb begin
      tpu_in = tpu_ff;
      if (csr_write && csr_hit) begin
         tpu_in = pwdata[TPU_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff <= TPU_RESET;
      end else begin
         tpu_ff <= tpu_in;
      end
   end

   i2cbb_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_tx_byte   (req_tx_byte),
      .req_sda_in    (req_sda_in),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_pop      (head_pop)
   );

   i2cbb_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .ticks_per_us  (tpu_ff),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_pop      (head_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scl_level (rsp_scl_level),
      .rsp_sda_level (rsp_sda_level),
      .rsp_sda_drive (rsp_sda_drive),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_rx_byte   (rsp_rx_byte),
      .rsp_ack_ok    (rsp_ack_ok)
   );

endmodule

`default_nettype wire
